// ===== src/yrc_pkg.sv =====
// ----------------------------------------------------------------------------
// yrc_pkg
// types, constants and the channel clamp shared by the ycbcr to rgb crop core
// ----------------------------------------------------------------------------
package yrc_pkg;

	localparam int CFG_W  = 13;
	localparam int SUM_W  = 20;
	localparam int CHAN_W = 8;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_CODED_WIDTH    = 2'd0;
	localparam logic [IDX_W-1:0] REG_CODED_HEIGHT   = 2'd1;
	localparam logic [IDX_W-1:0] REG_DISPLAY_WIDTH  = 2'd2;
	localparam logic [IDX_W-1:0] REG_DISPLAY_HEIGHT = 2'd3;

	localparam logic [CFG_W-1:0] CFG_RESET = 13'd16;

	localparam int Y_OFFSET = 16;
	localparam int C_OFFSET = 128;
	localparam int K_Y      = 298;
	localparam int K_RV     = 409;
	localparam int K_GU     = 100;
	localparam int K_GV     = 208;
	localparam int K_BU     = 516;
	localparam int K_ROUND  = 128;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
	} pix_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_done;
	} rgb_t;

	typedef struct packed {
		logic keep;
		logic last;
	} win_t;

	function automatic logic [CHAN_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
		logic signed [SUM_W-9:0] v;
		v = (SUM_W-8)'(sum >>> 8);
		if (v < 0) begin
			return '0;
		end else if (v > (SUM_W-8)'(255)) begin
			return 8'd255;
		end else begin
			return v[CHAN_W-1:0];
		end
	endfunction

endpackage

// ===== src/yrc_window.sv =====
// ----------------------------------------------------------------------------
// yrc_window
// size registers, column and row counters and the display window decision
// ----------------------------------------------------------------------------
module yrc_window #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [yrc_pkg::IDX_W-1:0]  cfg_index,
	input  logic [yrc_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       advance,
	output yrc_pkg::win_t              win
);
	import yrc_pkg::*;

	localparam int CW    = $clog2(MAX_DIMENSION);
	localparam int CMP_W = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

	logic [CFG_W-1:0] coded_width_q, coded_height_q, display_width_q, display_height_q;
	logic [CW-1:0]    col_q, row_q;
	logic [CMP_W-1:0] cw, ch, dw, dh, col_x, row_x, col_inc, row_inc;
	logic             coded_ok, disp_ok;
	logic [CW-1:0]    col_n, row_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coded_width_q    <= CFG_RESET;
			coded_height_q   <= CFG_RESET;
			display_width_q  <= CFG_RESET;
			display_height_q <= CFG_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CODED_WIDTH:    coded_width_q    <= cfg_data;
				REG_CODED_HEIGHT:   coded_height_q   <= cfg_data;
				REG_DISPLAY_WIDTH:  display_width_q  <= cfg_data;
				REG_DISPLAY_HEIGHT: display_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cw      = CMP_W'(coded_width_q);
		ch      = CMP_W'(coded_height_q);
		dw      = CMP_W'(display_width_q);
		dh      = CMP_W'(display_height_q);
		col_x   = CMP_W'(col_q);
		row_x   = CMP_W'(row_q);
		col_inc = col_x + CMP_W'(1);
		row_inc = row_x + CMP_W'(1);

		coded_ok = (cw != '0) && (ch != '0) &&
		           (cw <= CMP_W'(MAX_DIMENSION)) && (ch <= CMP_W'(MAX_DIMENSION));
		disp_ok  = (dw != '0) && (dh != '0) && (dw <= cw) && (dh <= ch);

		win.keep = coded_ok && disp_ok && (col_x < dw) && (row_x < dh);
		win.last = (col_inc == dw) && (row_inc == dh);

		col_n = '0;
		row_n = '0;
		if (coded_ok) begin
			if (col_inc >= cw) begin
				col_n = '0;
				row_n = (row_inc >= ch) ? '0 : row_inc[CW-1:0];
			end else begin
				col_n = col_inc[CW-1:0];
				row_n = (row_x >= ch) ? '0 : row_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			col_q <= col_n;
			row_q <= row_n;
		end
	end

endmodule

// ===== src/yrc_convert.sv =====
// ----------------------------------------------------------------------------
// yrc_convert
// bt.601 integer ycbcr to rgb with rounding and clamping to eight bits
// ----------------------------------------------------------------------------
module yrc_convert (
	input  yrc_pkg::pix_t pix,
	input  logic          last,
	output yrc_pkg::rgb_t rgb
);
	import yrc_pkg::*;

	logic signed [SUM_W-1:0] c_v, d_v, e_v, yc, sum_r, sum_g, sum_b;

	always_comb begin
		c_v   = SUM_W'(pix.luma) - SUM_W'(Y_OFFSET);
		d_v   = SUM_W'(pix.chroma_blue) - SUM_W'(C_OFFSET);
		e_v   = SUM_W'(pix.chroma_red) - SUM_W'(C_OFFSET);
		yc    = c_v * SUM_W'(K_Y) + SUM_W'(K_ROUND);
		sum_r = yc + e_v * SUM_W'(K_RV);
		sum_g = yc - d_v * SUM_W'(K_GU) - e_v * SUM_W'(K_GV);
		sum_b = yc + d_v * SUM_W'(K_BU);

		rgb.red        = clamp_channel(sum_r);
		rgb.green      = clamp_channel(sum_g);
		rgb.blue       = clamp_channel(sum_b);
		rgb.frame_done = last;
	end

endmodule

// ===== src/yuv420_to_rgb24_crop_core.sv =====
// ----------------------------------------------------------------------------
// yuv420_to_rgb24_crop_core
// raster pixel stream to bt.601 rgb24, cropped to the top-left display window
// ----------------------------------------------------------------------------
// Takes one pixel per clock while pix_stall is low; each kept pixel is held in
// the input register, and the color math between it and the result register
// feeds rgb. Throughput is one item per clock while rgb_stall is low. Pixels
// outside the display window, or any pixel while the coded or display size is
// invalid, give no item. Size registers are written through cfg_write while
// the core is idle, a rule the user must keep; the core does not enforce it.
// They take effect on the next pixel and do not reset the counters.
module yuv420_to_rgb24_crop_core #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [yrc_pkg::IDX_W-1:0]  cfg_index,
	input  logic [yrc_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       pix_valid,
	output logic                       pix_stall,
	input  yrc_pkg::pix_t              pix,
	output logic                       rgb_valid,
	input  logic                       rgb_stall,
	output yrc_pkg::rgb_t              rgb
);
	import yrc_pkg::*;

	win_t  win;
	logic  pix_take, s1_move;
	logic  s1_valid;
	pix_t  pix_s1;
	logic  last_s1;
	rgb_t  rgb_n;

	assign s1_move   = s1_valid && (!rgb_valid || !rgb_stall);
	assign pix_stall = s1_valid && !s1_move;
	assign pix_take  = pix_valid && !pix_stall;

	yrc_window #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (pix_take),
		.win       (win)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (pix_take || s1_move) begin
			s1_valid <= pix_take && win.keep;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_take) begin
			pix_s1  <= pix;
			last_s1 <= win.last;
		end
	end

	yrc_convert u_convert (
		.pix  (pix_s1),
		.last (last_s1),
		.rgb  (rgb_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_valid <= 1'b0;
		end else if (!rgb_valid || !rgb_stall) begin
			rgb_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			rgb <= rgb_n;
		end
	end

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid |-> !pix_stall)
		else $error("input stalled with an empty input register");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rgb_valid) |-> $past(s1_valid))
		else $error("result appeared without a pending item");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_move) |=> s1_valid)
		else $error("pending item lost while output stalled");

endmodule
